// File: rtl/mbrtu_pkg.sv
// Shared types, constants and CRC helper for the Modbus RTU request framer.
package mbrtu_pkg;

  localparam int MAX_WRITE_REGS = 123;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_SINGLE = 2'd1;
  localparam logic [1:0] KIND_MULTI  = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  frame_kind;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] quantity_or_value;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       run_last;
    logic       error;
  } res_t;

  typedef enum logic [1:0] {
    JOB_ERR,
    JOB_HDR,
    JOB_PAY
  } job_op_t;

  typedef struct packed {
    job_op_t     op;
    logic        multi;
    logic        close;
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [15:0] reg_addr;
    logic [15:0] qv;
    logic [7:0]  data;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// File: rtl/modbus_rtu_request_framer_core.sv
// An accepted request beat is written into the job queue; the back end then registers its first frame byte onto frm.
// The back end emits one frame byte per cycle while frm is not stalled; a header
// gives 7 to 9 bytes, a payload beat 1 byte (3 on the last one), an error one flagged beat.
// Requests are taken every cycle while the four-entry job queue has room.
// Reset (rst, synchronous) empties the queue, closes any open frame, sets CRC to 0xFFFF.
module modbus_rtu_request_framer_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  mbrtu_pkg::req_t req,
  output logic            frm_valid,
  input  logic            frm_stall,
  output mbrtu_pkg::res_t frm
);
  import mbrtu_pkg::*;

  logic      push;
  logic      pop;
  job_t      wr_job;
  job_t      rd_job;
  q_status_t status;

  assign req_stall = status.full;
  assign push      = req_valid && !req_stall;

  mbrtu_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .req  (req),
    .job  (wr_job)
  );

  mbrtu_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .status (status)
  );

  mbrtu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (rd_job),
    .status    (status),
    .pop       (pop),
    .frm_valid (frm_valid),
    .frm_stall (frm_stall),
    .frm       (frm)
  );

endmodule

// File: rtl/mbrtu_front.sv
// Front end: accepts request beats, checks sequencing, and builds jobs.
module mbrtu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mbrtu_pkg::req_t req,
  output mbrtu_pkg::job_t job
);
  import mbrtu_pkg::*;

  logic       awaiting;
  logic       awaiting_next;
  logic [7:0] remaining;
  logic [7:0] remaining_next;
  logic [7:0] rem_dec;

  always_comb begin
    rem_dec        = remaining - 8'd1;
    awaiting_next  = awaiting;
    remaining_next = remaining;
    job.op         = JOB_ERR;
    job.multi      = (req.frame_kind == KIND_MULTI);
    job.close      = 1'b1;
    job.addr       = req.slave_address;
    job.func       = req.function_code;
    job.reg_addr   = req.register_address;
    job.qv         = req.quantity_or_value;
    job.data       = req.data_byte;
    if (req.cmd) begin
      if (awaiting) begin
        job.op         = JOB_PAY;
        job.close      = (rem_dec == 8'd0);
        remaining_next = rem_dec;
        if (rem_dec == 8'd0) awaiting_next = 1'b0;
      end
    end else if (!awaiting && (req.frame_kind inside {KIND_READ, KIND_SINGLE, KIND_MULTI}) &&
                 !(job.multi && req.quantity_or_value > 16'(MAX_WRITE_REGS))) begin
      job.op    = JOB_HDR;
      job.close = !(job.multi && req.quantity_or_value != 16'd0);
      if (!job.close) begin
        awaiting_next  = 1'b1;
        remaining_next = {req.quantity_or_value[6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting  <= 1'b0;
      remaining <= 8'd0;
    end else if (push) begin
      awaiting  <= awaiting_next;
      remaining <= remaining_next;
    end
  end

endmodule

// File: rtl/mbrtu_queue.sv
// Small job queue between the front end and the byte sequencer.
module mbrtu_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mbrtu_pkg::job_t      wr_job,
  input  logic                 pop,
  output mbrtu_pkg::job_t      rd_job,
  output mbrtu_pkg::q_status_t status
);
  import mbrtu_pkg::*;

  job_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign status.full  = (count == (QAW+1)'(QDEPTH));
  assign status.empty = (count == '0);
  assign rd_job       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      case ({push, pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/mbrtu_back.sv
// Back end: walks each job one frame byte per cycle while frm is not stalled, and keeps the running CRC.
module mbrtu_back (
  input  logic                 clk,
  input  logic                 rst,
  input  mbrtu_pkg::job_t      job,
  input  mbrtu_pkg::q_status_t status,
  output logic                 pop,
  output logic                 frm_valid,
  input  logic                 frm_stall,
  output mbrtu_pkg::res_t      frm
);
  import mbrtu_pkg::*;

  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [15:0] crc_in;
  logic [15:0] crc_upd;
  logic [3:0]  step;
  logic [3:0]  step_next;
  logic [3:0]  nb;
  logic [7:0]  cur_byte;
  logic        adv;
  logic        emit;
  res_t        res_next;

  assign adv  = !frm_valid || !frm_stall;
  assign emit = adv && !status.empty;

  always_comb begin
    if (job.op == JOB_PAY) nb = 4'd1;
    else if (job.multi)    nb = 4'd7;
    else                   nb = 4'd6;

    if (job.op == JOB_PAY) cur_byte = job.data;
    else begin
      case (step[2:0])
        3'd0:    cur_byte = job.addr;
        3'd1:    cur_byte = job.func;
        3'd2:    cur_byte = job.reg_addr[15:8];
        3'd3:    cur_byte = job.reg_addr[7:0];
        3'd4:    cur_byte = job.qv[15:8];
        3'd5:    cur_byte = job.qv[7:0];
        default: cur_byte = {job.qv[6:0], 1'b0};
      endcase
    end

    crc_in  = (job.op == JOB_HDR && step == 4'd0) ? CRC_INIT : crc;
    crc_upd = crc_byte(crc_in, cur_byte);

    res_next  = '0;
    crc_next  = crc;
    step_next = step;
    pop       = 1'b0;
    if (emit) begin
      unique case (job.op)
        JOB_ERR: begin
          res_next.frame_end = 1'b1;
          res_next.run_last  = 1'b1;
          res_next.error     = 1'b1;
          pop                = 1'b1;
        end
        JOB_HDR, JOB_PAY: begin
          if (step < nb) begin
            res_next.tx_byte  = cur_byte;
            crc_next          = crc_upd;
            step_next         = step + 4'd1;
            if (!job.close && step == nb - 4'd1) begin
              res_next.run_last = 1'b1;
              pop               = 1'b1;
              step_next         = 4'd0;
            end
          end else if (step == nb) begin
            res_next.tx_byte = crc[7:0];
            step_next        = step + 4'd1;
          end else begin
            res_next.tx_byte   = crc[15:8];
            res_next.frame_end = 1'b1;
            res_next.run_last  = 1'b1;
            crc_next           = CRC_INIT;
            pop                = 1'b1;
            step_next          = 4'd0;
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= CRC_INIT;
      step      <= 4'd0;
      frm_valid <= 1'b0;
    end else begin
      crc  <= crc_next;
      step <= step_next;
      if (adv) frm_valid <= !status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) frm <= res_next;
  end

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    frm_valid && frm.error |-> frm.frame_end && frm.run_last && frm.tx_byte == 8'h00)
    else $error("error beat malformed");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    frm_valid && frm.frame_end |-> frm.run_last)
    else $error("frame end without run_last");

  a_pop_on_emit: assert property (@(posedge clk) disable iff (rst)
    pop |-> emit)
    else $error("job popped without emitting a beat");

  a_crc_reinit: assert property (@(posedge clk) disable iff (rst)
    emit && res_next.frame_end && !res_next.error |=> crc == CRC_INIT)
    else $error("CRC not reinitialized after frame close");

endmodule
